// ===== rtl/core/lbpt_pkg.sv =====
// shared types, constants and helper functions of the layered blur tweener
package lbpt_pkg;

	localparam int LAYER_BITS  = 4;
	localparam int LAYERS      = 1 << LAYER_BITS;
	localparam int PROP_BITS   = 16;
	localparam int FIELD_W     = 16;
	localparam int LAYER_W     = 4;
	localparam int TIME_W      = 32;
	localparam int FRAC_BITS   = 16;
	localparam int STEP_W      = $clog2(FRAC_BITS);
	localparam int NPROPS      = 6;
	localparam int PIDX_W      = $clog2(NPROPS);
	localparam int CFG_IDX_W   = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int DIFF_W      = ((PROP_BITS > FIELD_W) ? PROP_BITS : FIELD_W) + 1;
	localparam int PROD_W      = DIFF_W + FRAC_BITS + 1;
	localparam int WIDE_W      = PROD_W + 1;
	localparam int ACC_W       = PROP_BITS + LAYER_BITS + 3;

	typedef enum logic {
		OP_START = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOP_ALPHA    = 3'd0,
		REG_BOTTOM_ALPHA = 3'd1,
		REG_SCALE_X      = 3'd2,
		REG_SCALE_Y      = 3'd3,
		REG_SHIFT_X      = 3'd4,
		REG_SHIFT_Y      = 3'd5
	} reg_idx_t;

	typedef logic signed [PROP_BITS-1:0] prop_t;
	typedef logic signed [FIELD_W-1:0]   field_t;
	typedef logic signed [WIDE_W-1:0]    wide_t;
	typedef logic signed [ACC_W-1:0]     acc_t;

	typedef struct packed {
		op_t               op;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] duration;
	} item_t;

	localparam wide_t PROP_MAX  = wide_t'({1'b0, {(PROP_BITS-1){1'b1}}});
	localparam wide_t PROP_MIN  = -PROP_MAX - wide_t'(1);
	localparam wide_t SCALE_ONE = wide_t'(256);
	localparam acc_t  ACC_ONE   = acc_t'(256);

	localparam field_t TARGET_RESET [NPROPS] = '{
		field_t'(0), field_t'(0), field_t'(256), field_t'(256), field_t'(0), field_t'(0)
	};

	function automatic prop_t sat_prop(input wide_t v);
		prop_t r;
		if (v > PROP_MAX) begin
			r = PROP_MAX[PROP_BITS-1:0];
		end else if (v < PROP_MIN) begin
			r = PROP_MIN[PROP_BITS-1:0];
		end else begin
			r = v[PROP_BITS-1:0];
		end
		return r;
	endfunction

	function automatic wide_t widen(input prop_t v);
		return WIDE_W'(v);
	endfunction

	function automatic field_t to_field(input prop_t v);
		return FIELD_W'(v);
	endfunction

endpackage

// ===== rtl/core/lbpt_if.sv =====
// channel interfaces: input items and layer results
interface lbpt_item_if;
	import lbpt_pkg::*;

	logic              valid;
	logic              ready;
	logic              operation;
	logic [TIME_W-1:0] now;
	logic [TIME_W-1:0] duration;

	modport source (output valid, output operation, output now, output duration, input ready);
	modport sink (input valid, input operation, input now, input duration, output ready);
endinterface

interface lbpt_layer_if;
	import lbpt_pkg::*;

	logic               valid;
	logic               ready;
	logic [LAYER_W-1:0] layer;
	field_t             pos_x;
	field_t             pos_y;
	field_t             scale_x;
	field_t             scale_y;
	field_t             alpha;
	logic               last;

	modport source (output valid, output layer, output pos_x, output pos_y, output scale_x,
		output scale_y, output alpha, output last, input ready);
	modport sink (input valid, input layer, input pos_x, input pos_y, input scale_x,
		input scale_y, input alpha, input last, output ready);
endinterface

// ===== rtl/core/lbpt_front.sv =====
// front end: accepts input words and queues them for the back end
module lbpt_front (
	input  logic               clk,
	input  logic               arst_n,
	lbpt_item_if.sink          items,
	output lbpt_pkg::item_t    q_item,
	output logic               q_valid,
	input  logic               q_pop
);
	import lbpt_pkg::*;

	item_t             buf_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	item_t             word;

	assign items.ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign push        = items.valid && items.ready;
	assign q_valid     = (cnt_q != '0);
	assign q_item      = buf_q[rd_q];

	always_comb begin
		word.op       = op_t'(items.operation);
		word.now      = items.now;
		word.duration = items.duration;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (q_pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= word;
		end
	end

endmodule

// ===== rtl/core/lbpt_back.sv =====
// back end: time fraction divider, property update and layer emission
module lbpt_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lbpt_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [lbpt_pkg::FIELD_W-1:0]   cfg_data,
	input  lbpt_pkg::item_t                q_item,
	input  logic                           q_valid,
	output logic                           q_pop,
	lbpt_layer_if.source                   layers
);
	import lbpt_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DIV  = 5'b00010,
		S_MUL  = 5'b00100,
		S_ADD  = 5'b01000,
		S_EMIT = 5'b10000
	} state_t;

	state_t                 state_q;
	field_t                 target_q [NPROPS];
	prop_t                  cur_q [NPROPS];
	logic [TIME_W-1:0]      rem_q;
	logic [TIME_W-1:0]      prev_q;
	logic [TIME_W-1:0]      elapsed_q;
	logic [TIME_W-1:0]      part_q;
	logic [FRAC_BITS-1:0]   frac_q;
	logic [STEP_W-1:0]      step_q;
	logic [PIDX_W-1:0]      k_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [LAYER_BITS-1:0]  layer_q;
	acc_t                   acc_x_q, acc_y_q, acc_sx_q, acc_sy_q, acc_b_q;
	logic                   out_valid_q;
	logic [LAYER_W-1:0]     o_layer_q;
	field_t                 o_px_q, o_py_q, o_sx_q, o_sy_q, o_al_q;
	logic                   o_last_q;

	logic [TIME_W-1:0]      elapsed_c;
	logic [TIME_W:0]        shifted;
	logic                   ge;
	logic [TIME_W:0]        part_next;
	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod_c;
	logic                   load;
	logic                   is_last;
	logic                   enter_emit;
	acc_t                   d_x, d_y, d_sx, d_sy, d_b;
	prop_t                  px, py, sx, sy, blend, al;

	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign elapsed_c = q_item.now - prev_q;

	// one quotient bit per cycle; partial remainder always below the divisor
	assign shifted   = {part_q, 1'b0};
	assign ge        = (shifted >= {1'b0, rem_q});
	assign part_next = ge ? (shifted - {1'b0, rem_q}) : shifted;

	assign diff   = DIFF_W'(target_q[k_q]) - DIFF_W'(cur_q[k_q]);
	assign prod_c = diff * $signed({1'b0, frac_q});

	assign load    = (state_q == S_EMIT) && (!out_valid_q || layers.ready);
	assign is_last = (layer_q == LAYER_BITS'(LAYERS - 1));

	// entering emission from a snap or after the last property update
	assign enter_emit = (q_pop && (q_item.op == OP_TICK) && !(elapsed_c < rem_q))
		|| ((state_q == S_ADD) && (k_q == PIDX_W'(NPROPS - 1)));

	// per-layer step of each ramp, accumulated so that acc holds step * layer
	assign d_x  = ACC_W'(cur_q[REG_SHIFT_X]);
	assign d_y  = ACC_W'(cur_q[REG_SHIFT_Y]);
	assign d_sx = ACC_W'(cur_q[REG_SCALE_X]) - ACC_ONE;
	assign d_sy = ACC_W'(cur_q[REG_SCALE_Y]) - ACC_ONE;
	assign d_b  = ACC_W'(cur_q[REG_BOTTOM_ALPHA]) - ACC_W'(cur_q[REG_TOP_ALPHA]);

	assign px    = sat_prop(WIDE_W'(acc_x_q >>> LAYER_BITS));
	assign py    = sat_prop(WIDE_W'(acc_y_q >>> LAYER_BITS));
	assign sx    = sat_prop(WIDE_W'(acc_sx_q >>> LAYER_BITS) + SCALE_ONE);
	assign sy    = sat_prop(WIDE_W'(acc_sy_q >>> LAYER_BITS) + SCALE_ONE);
	assign blend = sat_prop(widen(cur_q[REG_TOP_ALPHA]) + WIDE_W'(acc_b_q >>> LAYER_BITS));
	assign al    = sat_prop(WIDE_W'(blend >>> LAYER_BITS));

	assign layers.valid   = out_valid_q;
	assign layers.layer   = o_layer_q;
	assign layers.pos_x   = o_px_q;
	assign layers.pos_y   = o_py_q;
	assign layers.scale_x = o_sx_q;
	assign layers.scale_y = o_sy_q;
	assign layers.alpha   = o_al_q;
	assign layers.last    = o_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			rem_q       <= '0;
			prev_q      <= '0;
			for (int j = 0; j < NPROPS; j++) begin
				target_q[j] <= TARGET_RESET[j];
				cur_q[j]    <= '0;
			end
		end else begin
			if (cfg_we && (cfg_idx <= CFG_IDX_W'(REG_SHIFT_Y))) begin
				target_q[cfg_idx] <= cfg_data;
			end

			if (load) begin
				out_valid_q <= 1'b1;
			end else if (layers.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						prev_q <= q_item.now;
						if (q_item.op == OP_START) begin
							rem_q <= q_item.duration;
							if (q_item.duration == '0) begin
								for (int j = 0; j < NPROPS; j++) begin
									cur_q[j] <= sat_prop(WIDE_W'(target_q[j]));
								end
							end
						end else if (elapsed_c < rem_q) begin
							state_q <= S_DIV;
						end else begin
							rem_q <= '0;
							for (int j = 0; j < NPROPS; j++) begin
								cur_q[j] <= sat_prop(WIDE_W'(target_q[j]));
							end
							state_q <= S_EMIT;
						end
					end
				end
				S_DIV: begin
					if (step_q == STEP_W'(FRAC_BITS - 1)) begin
						rem_q   <= rem_q - elapsed_q;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					cur_q[k_q] <= sat_prop(widen(cur_q[k_q]) + WIDE_W'(prod_q >>> FRAC_BITS));
					if (k_q == PIDX_W'(NPROPS - 1)) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_EMIT: begin
					if (load && is_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			elapsed_q <= elapsed_c;
			part_q    <= elapsed_c;
			step_q    <= '0;
		end
		if (state_q == S_DIV) begin
			part_q <= part_next[TIME_W-1:0];
			frac_q <= {frac_q[FRAC_BITS-2:0], ge};
			step_q <= step_q + STEP_W'(1);
			k_q    <= '0;
		end
		if (state_q == S_MUL) begin
			prod_q <= prod_c;
		end
		if (state_q == S_ADD) begin
			k_q <= k_q + PIDX_W'(1);
		end
		if (enter_emit) begin
			layer_q  <= '0;
			acc_x_q  <= '0;
			acc_y_q  <= '0;
			acc_sx_q <= '0;
			acc_sy_q <= '0;
			acc_b_q  <= '0;
		end
		if (load) begin
			o_layer_q <= LAYER_W'(layer_q);
			o_px_q    <= to_field(px);
			o_py_q    <= to_field(py);
			o_sx_q    <= to_field(sx);
			o_sy_q    <= to_field(sy);
			o_al_q    <= to_field(al);
			o_last_q  <= is_last;
			layer_q   <= layer_q + LAYER_BITS'(1);
			acc_x_q   <= acc_x_q + d_x;
			acc_y_q   <= acc_y_q + d_y;
			acc_sx_q  <= acc_sx_q + d_sx;
			acc_sy_q  <= acc_sy_q + d_sy;
			acc_b_q   <= acc_b_q + d_b;
		end
	end

`ifndef SYNTHESIS
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q != '0))
		else $error("divide running with zero divisor");

	a_part_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (part_q < rem_q))
		else $error("partial remainder not below divisor");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(load && is_last) |=> ((state_q == S_IDLE) && out_valid_q && o_last_q))
		else $error("last layer did not end the tick");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DIV) || (state_q == S_MUL) || (state_q == S_ADD)) |-> !q_pop)
		else $error("word taken from queue while busy");
`endif

endmodule

// ===== rtl/core/layered_blur_param_tweener.sv =====
// top level: a start item is popped when the back end is idle and is done in its pop cycle
// a dividing tick runs the bit-per-cycle time divider, then each property in turn on the
// shared multiplier, then one layer word per cycle while the output takes them
// a snapping tick skips the divider and the multiplier and goes straight to the layer words
// a 2-word queue accepts items until full while the back end works; output stalls hold emission
// reset clears the queue and output, targets return to their reset values, properties and timer to zero
module layered_blur_param_tweener (
	input  logic                           clk,
	input  logic                           arst_n,
	lbpt_item_if.sink                      items,
	lbpt_layer_if.source                   layers,
	input  logic                           cfg_we,
	input  logic [lbpt_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [lbpt_pkg::FIELD_W-1:0]   cfg_data
);
	import lbpt_pkg::*;

	item_t q_item;
	logic  q_valid;
	logic  q_pop;

	lbpt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_pop   (q_pop)
	);

	lbpt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.q_item   (q_item),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.layers   (layers)
	);

endmodule

// ===== tb/lbpt_checker.sv =====
// scoreboard of the layered blur tweener: tracks the animation state and checks every layer word
module lbpt_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	lbpt_item_if                           items,
	lbpt_layer_if                          layers,
	input  logic                           cfg_we,
	input  logic [lbpt_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [lbpt_pkg::FIELD_W-1:0]   cfg_data,
	output int                             fails,
	output int                             pending
);
	import lbpt_pkg::*;

	localparam int     REPORT_LIMIT = 10;
	localparam longint PROP_HI      = (longint'(1) << (PROP_BITS - 1)) - 1;
	localparam longint PROP_LO      = -PROP_HI - 1;
	localparam longint SCALE_UNIT   = 256;

	typedef struct packed {
		logic [LAYER_W-1:0] layer;
		field_t             pos_x;
		field_t             pos_y;
		field_t             scale_x;
		field_t             scale_y;
		field_t             alpha;
		logic               last;
	} layer_word_t;

	layer_word_t       expected_words [$];
	field_t            targets [NPROPS];
	prop_t             props [NPROPS];
	logic [TIME_W-1:0] time_left;
	logic [TIME_W-1:0] last_now;

	function automatic prop_t clamp_prop(input longint v);
		if (v > PROP_HI) begin
			return prop_t'(PROP_HI);
		end else if (v < PROP_LO) begin
			return prop_t'(PROP_LO);
		end
		return prop_t'(v);
	endfunction

	task automatic snap_to_targets();
		for (int k = 0; k < NPROPS; k++) begin
			props[k] = clamp_prop(longint'(targets[k]));
		end
	endtask

	task automatic start_animation(input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] span);
		if (span == '0) begin
			snap_to_targets();
		end
		time_left = span;
		last_now  = now;
	endtask

	task automatic tick_animation(input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] elapsed;
		longint            frac;
		longint            diff;
		longint            top;
		longint            bot;
		longint            blend;
		layer_word_t       w;
		elapsed = now - last_now;
		if (elapsed < time_left) begin
			// fraction of the remaining time, unsigned Q0.16
			frac = (longint'(elapsed) << FRAC_BITS) / longint'(time_left);
			time_left = time_left - elapsed;
			for (int k = 0; k < NPROPS; k++) begin
				diff = longint'(targets[k]) - longint'(props[k]);
				props[k] = clamp_prop(longint'(props[k]) + ((diff * frac) >>> FRAC_BITS));
			end
		end else begin
			time_left = '0;
			snap_to_targets();
		end
		last_now = now;

		top = longint'(props[REG_TOP_ALPHA]);
		bot = longint'(props[REG_BOTTOM_ALPHA]);
		for (int i = 0; i < LAYERS; i++) begin
			w.layer   = LAYER_W'(i);
			w.pos_x   = clamp_prop((longint'(props[REG_SHIFT_X]) * i) >>> LAYER_BITS);
			w.pos_y   = clamp_prop((longint'(props[REG_SHIFT_Y]) * i) >>> LAYER_BITS);
			w.scale_x = clamp_prop(SCALE_UNIT +
				(((longint'(props[REG_SCALE_X]) - SCALE_UNIT) * i) >>> LAYER_BITS));
			w.scale_y = clamp_prop(SCALE_UNIT +
				(((longint'(props[REG_SCALE_Y]) - SCALE_UNIT) * i) >>> LAYER_BITS));
			blend     = longint'(clamp_prop(top + (((bot - top) * i) >>> LAYER_BITS)));
			w.alpha   = clamp_prop(blend >>> LAYER_BITS);
			w.last    = (i == LAYERS - 1);
			expected_words.push_back(w);
		end
	endtask

	task automatic check_word();
		layer_word_t seen;
		layer_word_t want;
		seen = '{layer: layers.layer, pos_x: layers.pos_x, pos_y: layers.pos_y,
			scale_x: layers.scale_x, scale_y: layers.scale_y, alpha: layers.alpha,
			last: layers.last};
		if (expected_words.size() == 0) begin
			fails++;
			if (fails <= REPORT_LIMIT) begin
				$display("unexpected layer word: layer %0d pos %0d,%0d scale %0d,%0d",
					seen.layer, seen.pos_x, seen.pos_y, seen.scale_x, seen.scale_y);
				$display("                       alpha %0d", seen.alpha);
			end
		end else begin
			want = expected_words.pop_front();
			if (seen !== want) begin
				fails++;
				if (fails <= REPORT_LIMIT) begin
					$display("mismatch: expected layer %0d pos %0d,%0d scale %0d,%0d %0d %0b",
						want.layer, want.pos_x, want.pos_y, want.scale_x, want.scale_y,
						want.alpha, want.last);
					$display("          got      layer %0d pos %0d,%0d scale %0d,%0d %0d %0b",
						seen.layer, seen.pos_x, seen.pos_y, seen.scale_x, seen.scale_y,
						seen.alpha, seen.last);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_words.delete();
			for (int k = 0; k < NPROPS; k++) begin
				targets[k] = TARGET_RESET[k];
				props[k]   = '0;
			end
			time_left = '0;
			last_now  = '0;
			fails     = 0;
		end else begin
			if (layers.valid && layers.ready) begin
				check_word();
			end
			if (items.valid && items.ready) begin
				if (items.operation == OP_TICK) begin
					tick_animation(items.now);
				end else begin
					start_animation(items.now, items.duration);
				end
			end
			// writes to unused indexes are dropped by the block
			if (cfg_we && cfg_idx < NPROPS) begin
				targets[cfg_idx] = field_t'(cfg_data);
			end
		end
		pending = expected_words.size();
	end

endmodule

// ===== tb/tb_top.sv =====
// testbench top of the layered blur tweener: clock, reset, stimulus and verdict
module tb_top;
	import lbpt_pkg::*;

	localparam int PERIOD         = 12;
	localparam int RESET_CYCLES   = 8;
	localparam int SETTLE_CYCLES  = 64;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES         = 8;
	localparam int CALM_PHASE     = 6;
	localparam int PHASE_ITEMS    = 30;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	localparam field_t FIELD_TOP    = 16'sh7FFF;
	localparam field_t FIELD_BOTTOM = 16'sh8000;

	typedef field_t target_set_t [NPROPS];

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [FIELD_W-1:0]   cfg_data;
	int                   fails;
	int                   pending;
	bit                   calm = 1'b0;
	logic [TIME_W-1:0]    clock_now;
	int                   idle_cycles;

	lbpt_item_if  items ();
	lbpt_layer_if layers ();

	layered_blur_param_tweener i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items),
		.layers   (layers),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	lbpt_checker i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items),
		.layers   (layers),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.fails    (fails),
		.pending  (pending)
	);

	always #(PERIOD / 2) clk = ~clk;

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic send_item(input op_t op, input logic [TIME_W-1:0] now,
		input logic [TIME_W-1:0] span);
		if (!calm && $urandom_range(0, 3) == 0) begin
			items.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		items.valid     <= 1'b1;
		items.operation <= op;
		items.now       <= now;
		items.duration  <= span;
		do begin
			@(posedge clk);
		end while (!items.ready);
		@(negedge clk);
	endtask

	// hold the sender until every layer word is in, then let a start item finish too
	task automatic settle_block();
		items.valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_targets(input target_set_t goal, input bit poke_spare);
		reg_idx_t r;
		r = REG_TOP_ALPHA;
		repeat (NPROPS) begin
			cfg_we   <= 1'b1;
			cfg_idx  <= r;
			cfg_data <= goal[r];
			@(negedge clk);
			r = r.next();
		end
		if (poke_spare) begin
			cfg_idx  <= ($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B;
			cfg_data <= FIELD_W'($urandom);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_phase(input int budget);
		int                sent;
		logic [TIME_W-1:0] span;
		logic [TIME_W-1:0] step;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(0, 7) == 0) begin
				// stray word with an arbitrary timer value
				send_item(op_t'($urandom_range(0, 1)), $urandom, $urandom);
				sent++;
			end else begin
				case ($urandom_range(0, 9))
					0: span = '0;
					1: span = $urandom;
					2, 3, 4, 5: span = $urandom_range(1, 64);
					default: span = $urandom_range(65, 100000);
				endcase
				send_item(OP_START, clock_now, span);
				sent++;
				repeat ($urandom_range(1, 8)) begin
					case ($urandom_range(0, 7))
						0: step = '0;
						1: step = $urandom;
						2, 3, 4: step = $urandom_range(1, 8);
						default: step = $urandom_range(1,
							(span == 0) ? 16 : ((span > 100000) ? 100000 : span));
					endcase
					clock_now = clock_now + step;
					send_item(OP_TICK, clock_now, $urandom);
					sent++;
				end
			end
		end
	endtask

	initial begin
		layers.ready <= 1'b1;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				layers.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
				layers.ready <= 1'b1;
			end
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((items.valid && items.ready) || (layers.valid && layers.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		target_set_t goal;
		items.valid     <= 1'b0;
		items.operation <= OP_START;
		items.now       <= '0;
		items.duration  <= '0;
		cfg_we          <= 1'b0;
		cfg_idx         <= REG_TOP_ALPHA;
		cfg_data        <= '0;
		arst_n          <= 1'b0;
		clock_now = $urandom;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// nothing running yet: the tick snaps to the reset targets
		send_item(OP_TICK, 32'h0000_0000, 32'hFFFF_FFFF);
		send_item(OP_START, 32'hFFFF_FFFF, 32'h0000_0000);
		send_item(OP_TICK, 32'hFFFF_FFFF, 32'h0000_0000);
		settle_block();

		goal = '{FIELD_TOP, FIELD_BOTTOM, FIELD_BOTTOM, FIELD_TOP, FIELD_TOP, FIELD_BOTTOM};
		write_targets(goal, 1'b1);
		// timer wraps, then zero elapsed, then the largest fraction, then elapsed equals remaining
		send_item(OP_START, 32'hFFFF_FFF0, 32'd1000);
		send_item(OP_TICK, 32'h0000_0010, 32'h0000_0000);
		send_item(OP_TICK, 32'h0000_0010, 32'h5555_5555);
		send_item(OP_TICK, 32'h0000_0010 + 32'd967, 32'hAAAA_AAAA);
		send_item(OP_TICK, 32'h0000_0010 + 32'd968, 32'h0000_0000);
		send_item(OP_START, 32'h0000_0005, 32'hFFFF_FFFF);
		send_item(OP_TICK, 32'h0000_0003, 32'h0000_0000);
		settle_block();

		goal = '{FIELD_BOTTOM, FIELD_TOP, FIELD_TOP, FIELD_BOTTOM, FIELD_BOTTOM, FIELD_TOP};
		write_targets(goal, 1'b1);
		send_item(OP_START, 32'h0000_0000, 32'hFFFF_FFFF);
		send_item(OP_TICK, 32'h0000_0001, 32'hFFFF_FFFF);
		send_item(OP_TICK, 32'h8000_0000, 32'h0000_0000);
		// elapsed wraps past the remaining time
		send_item(OP_TICK, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_START, 32'h0000_0007, 32'h0000_0000);
		send_item(OP_TICK, 32'h0000_0007, 32'h0000_0000);

		for (int phase = 0; phase < PHASES; phase++) begin
			settle_block();
			calm = (phase >= CALM_PHASE);
			for (int k = 0; k < NPROPS; k++) begin
				case (phase)
					0: goal[k] = FIELD_TOP;
					1: goal[k] = FIELD_BOTTOM;
					default: begin
						if ($urandom_range(0, 3) == 0) begin
							goal[k] = ($urandom_range(0, 1) == 0) ? FIELD_TOP : FIELD_BOTTOM;
						end else begin
							goal[k] = field_t'($urandom);
						end
					end
				endcase
			end
			write_targets(goal, $urandom_range(0, 2) == 0);
			run_phase(PHASE_ITEMS);
		end
		settle_block();

		if (fails == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/lbpt_pkg.sv
rtl/core/lbpt_if.sv
rtl/core/lbpt_front.sv
rtl/core/lbpt_back.sv
rtl/core/layered_blur_param_tweener.sv
tb/lbpt_checker.sv
tb/tb_top.sv
